FILE: hdl/wst_pkg.sv
package wst_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int MASK_W     = 16;
   localparam int ID_W       = 32;
   localparam int TICK_W     = 32;

   localparam logic [1:0] MODE_SUBMIT  = 2'd0;
   localparam logic [1:0] MODE_DELAYED = 2'd1;
   localparam logic [1:0] MODE_UPDATE  = 2'd2;
   localparam logic [1:0] MODE_QUERY   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_STEP = 2'd2;

   localparam logic [TICK_W-1:0] DELAY_ROUND = 32'd9;
   localparam logic [31:0]       RECIP_FIVE  = 32'hCCCC_CCCD;
   localparam int                RECIP_SHIFT = 34;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TICK_W-1:0] current_tick;
      logic [31:0]       wait_ms;
      logic              step_present;
      logic [ID_W-1:0]   query_id;
      logic [MASK_W-1:0] step_done_mask;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]   work_id;
      logic [1:0]        status;
      logic              is_finished;
      logic [MASK_W-1:0] ran_mask;
      logic [MASK_W-1:0] completed_mask;
   } rsp_payload_type;

   typedef struct packed {
      logic              submit;
      logic              update;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] wake;
      logic [ID_W-1:0]   ident;
      logic [ID_W-1:0]   qid;
   } wst_cmd_type;

   typedef struct packed {
      logic taken;
      logic found;
      logic fin;
   } wst_link_type;

endpackage

FILE: hdl/wst_wake.sv
module wst_wake
   import wst_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [31:0]       wait_ms,
   input  logic [TICK_W-1:0] now,
   output logic [TICK_W-1:0] wake_at
);

   logic [32:0]              rounded;
   logic [31:0]              half;
   logic [63:0]              product;
   logic [63-RECIP_SHIFT:0]  ticks_ff;
   logic [63-RECIP_SHIFT:0]  ticks_in;
   logic [TICK_W:0]          sum;

   // ceil(delay / 10) as floor(floor((delay + 9) / 2) / 5)
   assign rounded  = {1'b0, wait_ms} + {1'b0, DELAY_ROUND};
   assign half     = rounded[32:1];
   assign product  = {32'd0, half} * {32'd0, RECIP_FIVE};
   assign ticks_in = product[63:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (load) begin
         ticks_ff <= ticks_in;
      end
   end

   assign sum = {1'b0, now} + {{(TICK_W + RECIP_SHIFT - 63){1'b0}}, ticks_ff};
   assign wake_at = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];

endmodule

FILE: hdl/wst_cell.sv
module wst_cell
   import wst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  wst_cmd_type  cmd,
   input  logic         done_bit,
   input  wst_link_type link_in,
   output wst_link_type link_out,
   output logic         claim,
   output logic         ran,
   output logic         comp
);

   logic              active_ff, active_in;
   logic              finished_ff, finished_in;
   logic [ID_W-1:0]   ident_ff, ident_in;
   logic [TICK_W-1:0] wake_ff, wake_in;
   logic              id_hit;

   assign claim  = cmd.submit & ~link_in.taken & ~active_ff;
   assign ran    = cmd.update & active_ff & (cmd.now >= wake_ff);
   assign comp   = ran & done_bit;
   assign id_hit = (ident_ff == cmd.qid);

   assign link_out.taken = link_in.taken | ~active_ff;
   assign link_out.found = link_in.found | id_hit;
   assign link_out.fin   = (~link_in.found & id_hit) ? finished_ff : link_in.fin;

   always_comb begin
      active_in   = active_ff;
      finished_in = finished_ff;
      ident_in    = ident_ff;
      wake_in     = wake_ff;
      if (claim) begin
         active_in   = 1'b1;
         finished_in = 1'b0;
         ident_in    = cmd.ident;
         wake_in     = cmd.wake;
      end else if (comp) begin
         active_in   = 1'b0;
         finished_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         finished_ff <= 1'b0;
         ident_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         finished_ff <= finished_in;
         ident_ff    <= ident_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
   end

endmodule

FILE: hdl/timed_work_slot_table.sv
// the item is registered at accept; the result is registered at the end of the exec pass, for every mode
// a new item is taken only in the idle state, not during an exec pass; the slot chain resolves one item per pass
// a delayed submit's tick count comes from a 32x32 multiply registered at accept
// a new item is taken while the previous result waits in the output register
// reset (synchronous, active high) clears every slot and sets the next id to 1
module timed_work_slot_table
   import wst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   req_payload_type   item_ff;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   next_ident_ff, next_ident_in;
   logic              accept, exec_go, is_submit, table_full;
   logic [TICK_W-1:0] delayed_wake;
   wst_cmd_type       cmd;
   wst_link_type      links [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0] claims, rans, comps, dones;
   logic [MASK_W-1:0] ran_mask, comp_mask;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign exec_go   = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_ready);
   assign is_submit = (item_ff.mode == MODE_SUBMIT) | (item_ff.mode == MODE_DELAYED);

   wst_wake u_wake (
      .clock     (clock),
      .load      (accept),
      .wait_ms   (req_payload.wait_ms),
      .now       (item_ff.current_tick),
      .wake_at   (delayed_wake)
   );

   assign cmd.submit = exec_go & is_submit & item_ff.step_present;
   assign cmd.update = exec_go & (item_ff.mode == MODE_UPDATE);
   assign cmd.now    = item_ff.current_tick;
   assign cmd.wake   = (item_ff.mode == MODE_DELAYED) ? delayed_wake : item_ff.current_tick;
   assign cmd.ident  = next_ident_ff;
   assign cmd.qid    = item_ff.query_id;

   assign links[0] = '{taken: 1'b0, found: 1'b0, fin: 1'b0};

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      if (i < MASK_W) begin : g_done
         assign dones[i] = item_ff.step_done_mask[i];
      end else begin : g_nodone
         assign dones[i] = 1'b0;
      end
      wst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .done_bit (dones[i]),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .claim    (claims[i]),
         .ran      (rans[i]),
         .comp     (comps[i])
      );
   end

   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < SLOT_COUNT) begin : g_used
         assign ran_mask[j]  = rans[j];
         assign comp_mask[j] = comps[j];
      end else begin : g_unused
         assign ran_mask[j]  = 1'b0;
         assign comp_mask[j] = 1'b0;
      end
   end

   assign table_full = ~links[SLOT_COUNT].taken;

   always_comb begin
      rsp_in        = '0;
      next_ident_in = next_ident_ff;
      if (is_submit) begin
         if (!item_ff.step_present) begin
            rsp_in.status = STATUS_NO_STEP;
         end else if (table_full) begin
            rsp_in.status = STATUS_FULL;
         end else begin
            rsp_in.status  = STATUS_OK;
            rsp_in.work_id = next_ident_ff;
            next_ident_in  = next_ident_ff + 1'b1;
            if (next_ident_in == '0) begin
               next_ident_in = {{(ID_W-1){1'b0}}, 1'b1};
            end
         end
      end else if (item_ff.mode == MODE_UPDATE) begin
         rsp_in.ran_mask       = ran_mask;
         rsp_in.completed_mask = comp_mask;
      end else begin
         rsp_in.is_finished = (item_ff.query_id != '0) & links[SLOT_COUNT].fin;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         next_ident_ff <= {{(ID_W-1){1'b0}}, 1'b1};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            next_ident_ff <= next_ident_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_rise_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised without an exec pass");

   a_ident_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_ident_ff != '0)
      else $error("next id is zero");

   a_single_claim: assert property (@(posedge clock) disable iff (reset)
      $onehot0(claims))
      else $error("more than one slot claimed");

   a_comp_within_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.completed_mask & ~rsp_ff.ran_mask) == '0))
      else $error("completed slot that did not run");
`endif

endmodule
